// ===== rtl/assert_macros.svh =====
// assertion macros used by rtl/bignum_scale_by_power.sv
// no dependencies; the macro bodies are empty in synthesis builds
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property checked on every rising clock edge outside reset
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// property checked on every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_RST(label, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== rtl/bsp_pkg.sv =====
// constants and widths for the base-1e9 power scaler
// no dependencies
`timescale 1ns / 1ps
package bsp_pkg;
    localparam int MAX_LIMBS = 64;
    localparam int IDX_W     = (MAX_LIMBS > 1) ? $clog2(MAX_LIMBS) : 1;
    localparam int CNT_W     = $clog2(MAX_LIMBS + 1);

    localparam int LIMB_W    = 30;
    localparam int FACTOR_W  = 8;
    localparam int EXP_W     = 16;
    localparam int PROD_W    = LIMB_W + FACTOR_W;
    localparam int Q_W       = 9;
    localparam int REM_W     = 32;

    localparam logic [LIMB_W-1:0] LIMB_BASE = 30'd1000000000;
    localparam logic [REM_W-1:0]  BASE_X1   = 32'd1000000000;
    localparam logic [REM_W-1:0]  BASE_X2   = 32'd2000000000;

    // quotient estimate: floor((t >> EST_LOW) * EST_K >> EST_SHIFT), never above t / 1e9
    localparam int EST_LOW   = 29;
    localparam int EST_A_W   = PROD_W - EST_LOW;
    localparam int EST_K_W   = 10;
    localparam logic [EST_K_W-1:0] EST_K = 10'd549;
    localparam int EST_SHIFT = 10;
    localparam int EST_P_W   = EST_A_W + EST_K_W;
endpackage

// ===== rtl/bignum_scale_by_power.sv =====
// top level: loads base-1e9 limbs, scales them by multiplier**exponent, emits them
// depends on bsp_pkg and assert_macros.svh
//
//   channel | handshake            | payload
//   --------+----------------------+---------------------------------------------
//   in      | in_valid / in_ready  | limb_value, limb_last, multiplier, exponent
//   out     | out_valid / out_ready| result_limb, result_last, overflow
//
// load: input words are taken back to back; in_ready is high only while loading
// compute: per pass and limb: memory read, 30x8 multiply, quotient estimate,
//   remainder subtract, correction; each pass ends with a step for the carry limb
// emit: per result word, registered memory read, then output register once it is free
// the next number loads while the final result word waits in the output register
// reset clears control state only; the limb memory keeps whatever it holds
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bignum_scale_by_power (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [bsp_pkg::LIMB_W-1:0]     limb_value,
    input  logic                           limb_last,
    input  logic [bsp_pkg::FACTOR_W-1:0]   multiplier,
    input  logic [bsp_pkg::EXP_W-1:0]      exponent,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [bsp_pkg::LIMB_W-1:0]     result_limb,
    output logic                           result_last,
    output logic                           overflow
);
    import bsp_pkg::*;

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_RD   = 4'd1;
    localparam logic [3:0] S_MUL  = 4'd2;
    localparam logic [3:0] S_EST  = 4'd3;
    localparam logic [3:0] S_SUB  = 4'd4;
    localparam logic [3:0] S_FIX  = 4'd5;
    localparam logic [3:0] S_TAIL = 4'd6;
    localparam logic [3:0] S_ERD  = 4'd7;
    localparam logic [3:0] S_EOUT = 4'd8;

    logic [3:0]          state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [CNT_W-1:0]    k_reg, k_next;
    logic [EXP_W-1:0]    pass_reg, pass_next;
    logic                ovf_reg, ovf_next;
    logic [FACTOR_W-1:0] factor_reg, factor_next;
    logic [EXP_W-1:0]    exp_reg, exp_next;
    logic [Q_W-1:0]      carry_reg, carry_next;
    logic [PROD_W-1:0]   t_reg, t_next;
    logic [Q_W-1:0]      qest_reg, qest_next;
    logic [REM_W-1:0]    r_reg, r_next;

    logic                out_valid_reg, out_valid_next;
    logic [LIMB_W-1:0]   out_limb_reg, out_limb_next;
    logic                out_last_reg, out_last_next;
    logic                out_ovf_reg, out_ovf_next;

    logic [LIMB_W-1:0]   mem [MAX_LIMBS];
    logic [LIMB_W-1:0]   rdata_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [LIMB_W-1:0]   mem_wdata;

    logic                in_fire;
    logic                out_free;
    logic [EST_P_W-1:0]  est_prod;
    logic [PROD_W-1:0]   qbase;
    logic [PROD_W-1:0]   rem_full;
    logic                store_full;
    logic                last_pass;

    assign in_ready    = (state_reg == S_LOAD);
    assign in_fire     = in_valid && in_ready;
    assign out_free    = !out_valid_reg || out_ready;
    assign out_valid   = out_valid_reg;
    assign result_limb = out_limb_reg;
    assign result_last = out_last_reg;
    assign overflow    = out_ovf_reg;
    assign store_full  = (cnt_reg == CNT_W'(MAX_LIMBS));
    assign last_pass   = (pass_reg + EXP_W'(1) == exp_reg) || (factor_reg <= FACTOR_W'(1));

    assign est_prod = EST_P_W'(t_reg[PROD_W-1:EST_LOW]) * EST_P_W'(EST_K);
    assign qbase    = PROD_W'(qest_reg) * PROD_W'(LIMB_BASE);
    assign rem_full = t_reg - qbase;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[k_reg[IDX_W-1:0]];
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        pass_next      = pass_reg;
        ovf_next       = ovf_reg;
        factor_next    = factor_reg;
        exp_next       = exp_reg;
        carry_next     = carry_reg;
        t_next         = t_reg;
        qest_next      = qest_reg;
        r_next         = r_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_limb_next  = out_limb_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[IDX_W-1:0];
        mem_wdata      = limb_value;

        case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    if (!store_full)
                    begin
                        mem_we   = 1'b1;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (limb_last)
                    begin
                        factor_next = multiplier;
                        exp_next    = exponent;
                        pass_next   = '0;
                        k_next      = '0;
                        carry_next  = '0;
                        state_next  = (exponent == '0) ? S_ERD : S_RD;
                    end
                end
            end
            S_RD:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                t_next = PROD_W'(rdata_reg) * PROD_W'(factor_reg) + PROD_W'(carry_reg);
                state_next = S_EST;
            end
            S_EST:
            begin
                qest_next  = est_prod[EST_SHIFT +: Q_W];
                state_next = S_SUB;
            end
            S_SUB:
            begin
                r_next     = rem_full[REM_W-1:0];
                state_next = S_FIX;
            end
            S_FIX:
            begin
                // estimate is at most two below the true quotient
                mem_we    = 1'b1;
                mem_waddr = k_reg[IDX_W-1:0];
                if (r_reg >= BASE_X2)
                begin
                    mem_wdata  = LIMB_W'(r_reg - BASE_X2);
                    carry_next = qest_reg + Q_W'(2);
                end
                else if (r_reg >= BASE_X1)
                begin
                    mem_wdata  = LIMB_W'(r_reg - BASE_X1);
                    carry_next = qest_reg + Q_W'(1);
                end
                else
                begin
                    mem_wdata  = LIMB_W'(r_reg);
                    carry_next = qest_reg;
                end
                k_next     = k_reg + CNT_W'(1);
                state_next = (k_reg + CNT_W'(1) == cnt_reg) ? S_TAIL : S_RD;
            end
            S_TAIL:
            begin
                if (carry_reg != '0)
                begin
                    if (!store_full)
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = LIMB_W'(carry_reg);
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                end
                k_next     = '0;
                carry_next = '0;
                pass_next  = pass_reg + EXP_W'(1);
                state_next = last_pass ? S_ERD : S_RD;
            end
            S_ERD:
            begin
                state_next = S_EOUT;
            end
            S_EOUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_limb_next  = rdata_reg;
                    out_last_next  = (k_reg + CNT_W'(1) == cnt_reg);
                    out_ovf_next   = ovf_reg;
                    k_next         = k_reg + CNT_W'(1);
                    if (k_reg + CNT_W'(1) == cnt_reg)
                    begin
                        cnt_next   = '0;
                        ovf_next   = 1'b0;
                        k_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_ERD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            cnt_reg       <= '0;
            k_reg         <= '0;
            pass_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            k_reg         <= k_next;
            pass_reg      <= pass_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        factor_reg   <= factor_next;
        exp_reg      <= exp_next;
        carry_reg    <= carry_next;
        t_reg        <= t_next;
        qest_reg     <= qest_next;
        r_reg        <= r_next;
        out_limb_reg <= out_limb_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    `ASSERT_RST(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(MAX_LIMBS), "limb count above store depth")
    `ASSERT_RST(a_k_bound, clk, rst_n, k_reg <= cnt_reg, "limb index beyond limb count")
    `ASSERT_RST(a_rem_range, clk, rst_n, (state_reg == S_FIX) |-> (r_reg < BASE_X2 + BASE_X1), "quotient estimate off by more than two")
    `ASSERT_RST(a_emit_nonempty, clk, rst_n, (state_reg == S_ERD) |-> (cnt_reg != '0), "emit started with empty store")
endmodule

// ===== tb/sv/bignum_scale_by_power_checker.sv =====
// checker for the base-1e9 power scaler: predicts product words and compares them
// depends on bsp_pkg; watches both channels of bignum_scale_by_power from outside
`timescale 1ns / 1ps
module bignum_scale_by_power_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    input  logic                         in_ready,
    input  logic [bsp_pkg::LIMB_W-1:0]   limb_value,
    input  logic                         limb_last,
    input  logic [bsp_pkg::FACTOR_W-1:0] multiplier,
    input  logic [bsp_pkg::EXP_W-1:0]    exponent,
    input  logic                         out_valid,
    input  logic                         out_ready,
    input  logic [bsp_pkg::LIMB_W-1:0]   result_limb,
    input  logic                         result_last,
    input  logic                         overflow,
    output int                           fail_count,
    output int                           words_waiting,
    output int                           words_checked,
    output int                           overflow_words
);

    localparam longint unsigned DIGIT_BASE  = 64'(bsp_pkg::LIMB_BASE);

    typedef struct packed {
        logic [bsp_pkg::LIMB_W-1:0] limb;
        logic                       last;
        logic                       ovf;
    } product_word_t;

    logic [bsp_pkg::LIMB_W-1:0] digits [bsp_pkg::MAX_LIMBS];
    int unsigned                digit_count   = 0;
    logic                       store_dropped = 1'b0;
    product_word_t              product_words [$];

    // one limb-wise multiply with carry over the held digits
    task automatic multiply_once(input longint unsigned factor);
        longint unsigned acc;
        longint unsigned carry;
        longint unsigned digit;
        int unsigned     k;
        carry = 0;
        for (k = 0; k < digit_count; k++)
        begin
            digit     = 64'(digits[k]);
            acc       = digit * factor + carry;
            digits[k] = bsp_pkg::LIMB_W'(acc % DIGIT_BASE);
            carry     = acc / DIGIT_BASE;
        end
        if (carry != 0)
        begin
            if (digit_count < bsp_pkg::MAX_LIMBS)
            begin
                digits[digit_count] = bsp_pkg::LIMB_W'(carry);
                digit_count++;
            end
            else
                store_dropped = 1'b1;
        end
    endtask

    task automatic absorb_word(input logic [bsp_pkg::LIMB_W-1:0]   value,
                               input logic                         is_last,
                               input logic [bsp_pkg::FACTOR_W-1:0] factor,
                               input logic [bsp_pkg::EXP_W-1:0]    passes);
        int unsigned   p;
        int unsigned   k;
        product_word_t w;
        if (digit_count < bsp_pkg::MAX_LIMBS)
        begin
            digits[digit_count] = value;
            digit_count++;
        end
        else
            store_dropped = 1'b1;
        if (is_last)
        begin
            for (p = 0; p < passes; p++)
            begin
                multiply_once(64'(factor));
                // factor zero or one: further passes change nothing
                if (factor <= 1)
                    break;
            end
            for (k = 0; k < digit_count; k++)
            begin
                w.limb = digits[k];
                w.last = (k + 1 == digit_count);
                w.ovf  = store_dropped;
                product_words.push_back(w);
            end
            digit_count   = 0;
            store_dropped = 1'b0;
        end
    endtask

    always @(posedge clk)
    begin
        product_word_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (product_words.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: result word expected none actual limb %0d last %0b overflow %0b",
                             $time, result_limb, result_last, overflow);
                end
                else
                begin
                    want = product_words.pop_front();
                    if (result_limb !== want.limb)
                    begin
                        fail_count++;
                        $display("%0t: word %0d result_limb expected %0d actual %0d",
                                 $time, words_checked, want.limb, result_limb);
                    end
                    if (result_last !== want.last)
                    begin
                        fail_count++;
                        $display("%0t: word %0d result_last expected %0b actual %0b",
                                 $time, words_checked, want.last, result_last);
                    end
                    if (overflow !== want.ovf)
                    begin
                        fail_count++;
                        $display("%0t: word %0d overflow expected %0b actual %0b",
                                 $time, words_checked, want.ovf, overflow);
                    end
                    if (want.ovf)
                        overflow_words++;
                end
                words_checked++;
            end
            if (in_valid && in_ready)
                absorb_word(limb_value, limb_last, multiplier, exponent);
            words_waiting = product_words.size();
        end
    end

endmodule

// ===== tb/sv/bignum_scale_by_power_test.sv =====
// top of the power scaler bench: drives limb words with random gaps and output stalls
// depends on bsp_pkg, bignum_scale_by_power and bignum_scale_by_power_checker
// directed corner numbers first, then random numbers of mixed length and exponent
`timescale 1ns / 1ps
module bignum_scale_by_power_test;

    localparam int                         ITEM_TARGET    = 280;
    localparam int                         HOLD_CYCLES    = 300;
    localparam int                         WATCHDOG_LIMIT = 40000;
    localparam int                         DRAIN_CYCLES   = 50;
    localparam logic [bsp_pkg::LIMB_W-1:0] LIMB_MAX       =
        bsp_pkg::LIMB_BASE - bsp_pkg::LIMB_W'(1);
    localparam logic [bsp_pkg::LIMB_W-1:0] RAW_MAX        = '1;

    logic                         clk;
    logic                         rst_n;
    logic                         in_valid;
    logic                         in_ready;
    logic [bsp_pkg::LIMB_W-1:0]   limb_value;
    logic                         limb_last;
    logic [bsp_pkg::FACTOR_W-1:0] multiplier;
    logic [bsp_pkg::EXP_W-1:0]    exponent;
    logic                         out_valid;
    logic                         out_ready;
    logic [bsp_pkg::LIMB_W-1:0]   result_limb;
    logic                         result_last;
    logic                         overflow;

    int   fail_count;
    int   words_waiting;
    int   words_checked;
    int   overflow_words;
    int   words_sent   = 0;
    int   numbers_sent = 0;
    int   quiet_cycles = 0;
    logic calm         = 1'b0;
    logic hold_rx      = 1'b0;

    bignum_scale_by_power dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .limb_value  (limb_value),
        .limb_last   (limb_last),
        .multiplier  (multiplier),
        .exponent    (exponent),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .result_limb (result_limb),
        .result_last (result_last),
        .overflow    (overflow)
    );

    bignum_scale_by_power_checker product_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .limb_value     (limb_value),
        .limb_last      (limb_last),
        .multiplier     (multiplier),
        .exponent       (exponent),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .result_limb    (result_limb),
        .result_last    (result_last),
        .overflow       (overflow),
        .fail_count     (fail_count),
        .words_waiting  (words_waiting),
        .words_checked  (words_checked),
        .overflow_words (overflow_words)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
            $display("TEST FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 65)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [bsp_pkg::LIMB_W-1:0] random_limb();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick == 0)
            return '0;
        if (pick == 1)
            return LIMB_MAX;
        // above the base: stored as given
        if (pick == 2)
            return bsp_pkg::LIMB_W'($urandom_range(int'(bsp_pkg::LIMB_BASE), int'(RAW_MAX)));
        return bsp_pkg::LIMB_W'($urandom_range(0, int'(LIMB_MAX)));
    endfunction

    task automatic send_word(input logic [bsp_pkg::LIMB_W-1:0]   value,
                             input logic                         is_last,
                             input logic [bsp_pkg::FACTOR_W-1:0] factor,
                             input logic [bsp_pkg::EXP_W-1:0]    passes);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   = 1'b1;
        limb_value = value;
        limb_last  = is_last;
        multiplier = factor;
        exponent   = passes;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        words_sent++;
        if (is_last)
            numbers_sent++;
    endtask

    // multiplier and exponent only matter on the last word; the rest carry noise
    task automatic send_number(input int                           len,
                               input logic [bsp_pkg::FACTOR_W-1:0] factor,
                               input logic [bsp_pkg::EXP_W-1:0]    passes,
                               input logic                         big_top);
        int                         i;
        logic [bsp_pkg::LIMB_W-1:0] value;
        for (i = 0; i < len; i++)
        begin
            value = random_limb();
            if (i == len - 1)
            begin
                if (big_top)
                    value = bsp_pkg::LIMB_W'($urandom_range(500000000, int'(LIMB_MAX)));
                send_word(value, 1'b1, factor, passes);
            end
            else
                send_word(value, 1'b0, bsp_pkg::FACTOR_W'($urandom),
                          bsp_pkg::EXP_W'($urandom));
        end
    endtask

    // receiver: ready runs broken by gaps, one long hold on request
    initial
    begin
        int run;
        int gap;
        out_ready = 1'b0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (hold_rx)
            begin
                hold_rx   = 1'b0;
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            run       = $urandom_range(1, 24);
            out_ready = 1'b1;
            repeat (run) @(negedge clk);
            gap = pick_gap();
            if (gap > 0)
            begin
                out_ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    initial
    begin
        int                           number_idx;
        int                           len;
        logic [bsp_pkg::FACTOR_W-1:0] factor;
        logic [bsp_pkg::EXP_W-1:0]    passes;
        in_valid   = 1'b0;
        limb_value = '0;
        limb_last  = 1'b0;
        multiplier = '0;
        exponent   = '0;
        rst_n      = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // zero with no passes, top digit times 255, raw limb left untouched
        send_word('0, 1'b1, 8'd0, 16'd0);
        send_word(LIMB_MAX, 1'b1, 8'd255, 16'd1);
        send_word(RAW_MAX, 1'b1, 8'd7, 16'd0);
        // multiplier one with full exponent: one pass folds the excess into a carry
        send_word(RAW_MAX, 1'b1, 8'd1, 16'hFFFF);
        send_word(LIMB_MAX, 1'b0, bsp_pkg::FACTOR_W'($urandom), bsp_pkg::EXP_W'($urandom));
        send_word(LIMB_MAX, 1'b1, 8'd0, 16'hFFFF);
        send_word(RAW_MAX, 1'b0, bsp_pkg::FACTOR_W'($urandom), bsp_pkg::EXP_W'($urandom));
        send_word('0, 1'b1, 8'd1, 16'd1);
        send_word(30'd1, 1'b1, 8'd2, 16'd100);
        send_word(30'd123456789, 1'b1, 8'd128, 16'd3);
        send_number(3, 8'd255, 16'd8, 1'b0);

        number_idx = 0;
        while (words_sent < ITEM_TARGET)
        begin
            // the held-off number and numbers 8 to 11 go in without gaps so the block backs up
            calm = (number_idx == 5) || (number_idx >= 8 && number_idx <= 11);
            if (number_idx == 5)
                hold_rx = 1'b1;
            if (number_idx == 0)
            begin
                // more limbs than the store holds
                len    = bsp_pkg::MAX_LIMBS + $urandom_range(1, 6);
                factor = bsp_pkg::FACTOR_W'($urandom);
                passes = bsp_pkg::EXP_W'($urandom_range(0, 3));
                send_number(len, factor, passes, 1'b0);
            end
            else if (number_idx == 1)
            begin
                // full store with a large top digit: the carry has no room
                factor = bsp_pkg::FACTOR_W'($urandom_range(2, 255));
                passes = bsp_pkg::EXP_W'($urandom_range(1, 3));
                send_number(bsp_pkg::MAX_LIMBS, factor, passes, 1'b1);
            end
            else
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(56, bsp_pkg::MAX_LIMBS)
                                                  : $urandom_range(1, 6);
                if (number_idx == 5)
                    len = 8;
                case ($urandom_range(0, 9))
                    0, 1:
                    begin
                        factor = bsp_pkg::FACTOR_W'($urandom_range(0, 1));
                        passes = bsp_pkg::EXP_W'($urandom);
                    end
                    2:
                    begin
                        factor = bsp_pkg::FACTOR_W'($urandom);
                        passes = '0;
                    end
                    default:
                    begin
                        factor = bsp_pkg::FACTOR_W'($urandom);
                        passes = bsp_pkg::EXP_W'($urandom_range(1, 6));
                    end
                endcase
                send_number(len, factor, passes, 1'b0);
            end
            number_idx++;
        end
        calm     = 1'b0;
        in_valid = 1'b0;

        wait (words_waiting == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("covered %0d numbers in %0d input words, %0d result words checked",
                 numbers_sent, words_sent, words_checked);
        $display("%0d result words flagged overflow, %0d mismatches",
                 overflow_words, fail_count);
        if (fail_count == 0 && words_waiting == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/bsp_pkg.sv
rtl/bignum_scale_by_power.sv
tb/sv/bignum_scale_by_power_checker.sv
tb/sv/bignum_scale_by_power_test.sv
